/* design/edb_pkg.sv */
// ----------------------------------------------------------------------------
// edb_pkg
// Shared types and codes for the event debouncer: request kinds, register
// indexes, the request and response payloads and the configuration set.
// ----------------------------------------------------------------------------
`default_nettype none

package edb_pkg;

    localparam int VALUE_W   = 32;
    localparam int CFG_TIME_W = 16;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        REQ_CALL   = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_FLUSH  = 2'd2,
        REQ_CANCEL = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_DELAY_MS    = 2'd0,
        CFG_LEADING_EN  = 2'd1,
        CFG_TRAILING_EN = 2'd2,
        CFG_MAX_WAIT_MS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        req_type_t            req_type;
        logic [VALUE_W-1:0]   value;
    } req_t;

    typedef struct packed {
        logic                 fire;
        logic [VALUE_W-1:0]   fire_value;
        logic                 pending_now;
    } rsp_t;

    typedef struct packed {
        logic [CFG_TIME_W-1:0] delay_ms;
        logic                  leading_en;
        logic                  trailing_en;
        logic [CFG_TIME_W-1:0] max_wait_ms;
    } cfg_t;

endpackage

`default_nettype wire

/* design/edb_engine.sv */
// ----------------------------------------------------------------------------
// edb_engine
// Debouncer state and its single-pass update: one request is applied per
// transfer and the matching response is produced in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module edb_engine #(
    parameter int DATA_W = 32,
    parameter int TIME_W = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire edb_pkg::cfg_t cfg,
    input  wire logic         req_take,
    input  wire edb_pkg::req_t req,
    output edb_pkg::rsp_t     rsp
);
    import edb_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic              pending_reg, pending_next;
    logic              leading_done_reg, leading_done_next;
    logic [TIME_W-1:0] countdown_reg, countdown_next;
    logic              active_reg, active_next;
    logic [TIME_W-1:0] age_reg, age_next;
    logic [DATA_W-1:0] last_value_reg, last_value_next;

    logic [TIME_W-1:0] delay_sat;
    logic [TIME_W-1:0] max_wait_sat;
    logic              fire;

    // Config times wider than the counters clamp to the largest count they can hold.
    generate
        if (TIME_W >= CFG_TIME_W) begin : g_no_sat
            assign delay_sat    = TIME_W'(cfg.delay_ms);
            assign max_wait_sat = TIME_W'(cfg.max_wait_ms);
        end else begin : g_sat
            assign delay_sat    = (|cfg.delay_ms[CFG_TIME_W-1:TIME_W]) ? TIME_MAX
                                                                        : cfg.delay_ms[TIME_W-1:0];
            assign max_wait_sat = (|cfg.max_wait_ms[CFG_TIME_W-1:TIME_W]) ? TIME_MAX
                                                                           : cfg.max_wait_ms[TIME_W-1:0];
        end
    endgenerate

    always_comb
    begin
        logic done;
        done              = 1'b0;
        fire              = 1'b0;
        pending_next      = pending_reg;
        leading_done_next = leading_done_reg;
        countdown_next    = countdown_reg;
        active_next       = active_reg;
        age_next          = age_reg;
        last_value_next   = last_value_reg;

        case (req.req_type)
            REQ_CALL:
            begin
                last_value_next = DATA_W'(req.value);
                if (!pending_reg)
                begin
                    age_next          = '0;
                    leading_done_next = 1'b0;
                end
                if (cfg.leading_en && !leading_done_next)
                begin
                    leading_done_next = 1'b1;
                    fire              = 1'b1;
                    done              = !cfg.trailing_en;
                end
                if (!done)
                begin
                    pending_next = 1'b1;
                    if ((max_wait_sat != '0) && (age_next >= max_wait_sat))
                    begin
                        fire     = 1'b1;
                        age_next = '0;
                    end
                    countdown_next = delay_sat;
                    active_next    = 1'b1;
                end
            end
            REQ_TICK:
            begin
                if (age_reg != TIME_MAX)
                begin
                    age_next = age_reg + TIME_W'(1);
                end
                if (active_reg)
                begin
                    // A countdown of zero or one expires on this tick.
                    if (countdown_reg <= TIME_W'(1))
                    begin
                        countdown_next    = '0;
                        active_next       = 1'b0;
                        fire              = cfg.trailing_en;
                        pending_next      = 1'b0;
                        leading_done_next = 1'b0;
                    end else begin
                        countdown_next = countdown_reg - TIME_W'(1);
                    end
                end
            end
            REQ_FLUSH:
            begin
                if (pending_reg)
                begin
                    countdown_next = '0;
                    active_next    = 1'b0;
                    fire           = 1'b1;
                end
            end
            REQ_CANCEL:
            begin
                countdown_next    = '0;
                active_next       = 1'b0;
                pending_next      = 1'b0;
                leading_done_next = 1'b0;
            end
            default:
            begin
                fire = 1'b0;
            end
        endcase

        rsp.fire        = fire;
        rsp.fire_value  = fire ? VALUE_W'(last_value_next) : '0;
        rsp.pending_now = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg      <= 1'b0;
            leading_done_reg <= 1'b0;
            countdown_reg    <= '0;
            active_reg       <= 1'b0;
            age_reg          <= '0;
            last_value_reg   <= '0;
        end else if (req_take)
        begin
            pending_reg      <= pending_next;
            leading_done_reg <= leading_done_next;
            countdown_reg    <= countdown_next;
            active_reg       <= active_next;
            age_reg          <= age_next;
            last_value_reg   <= last_value_next;
        end
    end

    // A running countdown always belongs to a pending burst.
    a_active_pending: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> pending_reg)
        else $error("countdown running without a pending burst");

    a_cancel_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && req.req_type == REQ_CANCEL) |=> (!pending_reg && !active_reg))
        else $error("cancel left the burst alive");

    a_flush_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && req.req_type == REQ_FLUSH && pending_reg) |=>
            (!active_reg && pending_reg))
        else $error("flush did not stop the countdown");

    a_age_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && req.req_type == REQ_TICK && age_reg == TIME_MAX) |=> age_reg == TIME_MAX)
        else $error("burst age wrapped");

endmodule

`default_nettype wire

/* design/edb_out_buf.sv */
// ----------------------------------------------------------------------------
// edb_out_buf
// Two-entry response buffer: a main output register plus a skid register,
// so the ready toward the request side is a plain flop.
// ----------------------------------------------------------------------------
`default_nettype none

module edb_out_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire edb_pkg::rsp_t push_data,
    output logic               has_room,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output edb_pkg::rsp_t      rsp
);
    import edb_pkg::*;

    logic  main_valid_reg, main_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    rsp_t  main_data_reg, main_data_next;
    rsp_t  skid_data_reg, skid_data_next;
    logic  drain;

    assign drain     = main_valid_reg && rsp_ready;
    assign has_room  = !skid_valid_reg;
    assign rsp_valid = main_valid_reg;
    assign rsp       = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;

        if (drain || !main_valid_reg)
        begin
            // Main slot frees up: refill from skid first, then from a new transfer.
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end else begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while output slot empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> has_room)
        else $error("response pushed into a full buffer");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && drain) |=> (main_valid_reg && main_data_reg == $past(skid_data_reg)))
        else $error("skid entry not promoted after drain");

endmodule

`default_nettype wire

/* design/event_debouncer_leading_trailing_core.sv */
// ----------------------------------------------------------------------------
// event_debouncer_leading_trailing_core
// Event debouncer with leading edge, trailing edge and maximum-wait fire.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready): a call carrying a value, a tick of
// one millisecond, a flush or a cancel. Every request gives exactly one
// response on rsp (valid/ready) with the fire flag, the stored value at the
// fire (zero otherwise) and the pending flag after the request.
// The whole update is one pass of logic at the request transfer; the
// response is registered and shown on rsp once earlier ones drain. Throughput
// is one request per cycle, limited only by the two-entry response buffer.
// When the receiver stalls, one more response is held in a skid register;
// req_ready drops only once both entries are full, and returns as soon as
// the receiver takes a transfer.
// Configuration (delay_ms, leading_en, trailing_en, max_wait_ms) is written
// via cfg_we/cfg_addr/cfg_wdata; the user must write it only while the block
// is idle, which the block does not enforce. Reset clears the burst state
// and buffer, and loads delay_ms 100, leading_en 0, trailing_en 1, max_wait_ms 0.
// ----------------------------------------------------------------------------
`default_nettype none

module event_debouncer_leading_trailing_core #(
    parameter int DATA_W = 32,
    parameter int TIME_W = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire edb_pkg::cfg_reg_t                 cfg_addr,
    input  wire logic [edb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire edb_pkg::req_t                     req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output edb_pkg::rsp_t                          rsp
);
    import edb_pkg::*;

    cfg_t  cfg_reg;
    logic  req_take;
    rsp_t  eng_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_ms    <= CFG_TIME_W'(100);
            cfg_reg.leading_en  <= 1'b0;
            cfg_reg.trailing_en <= 1'b1;
            cfg_reg.max_wait_ms <= '0;
        end else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DELAY_MS:    cfg_reg.delay_ms    <= cfg_wdata[CFG_TIME_W-1:0];
                CFG_LEADING_EN:  cfg_reg.leading_en  <= cfg_wdata[0];
                CFG_TRAILING_EN: cfg_reg.trailing_en <= cfg_wdata[0];
                CFG_MAX_WAIT_MS: cfg_reg.max_wait_ms <= cfg_wdata[CFG_TIME_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign req_take = req_valid && req_ready;

    edb_engine #(
        .DATA_W (DATA_W),
        .TIME_W (TIME_W)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .req_take (req_take),
        .req      (req),
        .rsp      (eng_rsp)
    );

    edb_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_take),
        .push_data (eng_rsp),
        .has_room  (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the event debouncer core. A scoreboard predicts
// the fire flag, fire value and pending flag of every accepted request and
// checks each response against the oldest prediction. Directed requests
// cover the special cases, a short tick run forces a max-wait fire, and
// random segments under several register settings and stall patterns
// cover the rest.
// ----------------------------------------------------------------------------

module tb;

    import edb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SEGMENTS = 12;
    localparam int SEGMENT_ITEMS = 140;

    class debounce_scoreboard;
        logic [15:0] delay_ms;
        logic        leading_en;
        logic        trailing_en;
        logic [15:0] max_wait_ms;

        logic        pending;
        logic        leading_done;
        logic [15:0] countdown;
        logic        counting;
        logic [15:0] burst_age;
        logic [31:0] last_value;

        rsp_t        fire_q[$];
        int          errors;

        function new();
            delay_ms = 16'd100;
            leading_en = 1'b0;
            trailing_en = 1'b1;
            max_wait_ms = 16'd0;
            pending = 1'b0;
            leading_done = 1'b0;
            countdown = 16'd0;
            counting = 1'b0;
            burst_age = 16'd0;
            last_value = 32'd0;
            errors = 0;
        endfunction

        function void apply_reg(cfg_reg_t addr, logic [15:0] data);
            case (addr)
                CFG_DELAY_MS:    delay_ms = data;
                CFG_LEADING_EN:  leading_en = data[0];
                CFG_TRAILING_EN: trailing_en = data[0];
                CFG_MAX_WAIT_MS: max_wait_ms = data;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return fire_q.size();
        endfunction

        // Advances the burst state by one accepted request and queues the
        // response it must produce.
        function void take_request(req_t r);
            logic fire;
            logic burst_over;
            rsp_t outcome;
            fire = 1'b0;
            burst_over = 1'b0;
            case (r.req_type)
                REQ_CALL:
                begin
                    last_value = r.value;
                    if (!pending)
                    begin
                        burst_age = 16'd0;
                        leading_done = 1'b0;
                    end
                    if (leading_en && !leading_done)
                    begin
                        leading_done = 1'b1;
                        fire = 1'b1;
                        // With trailing off, a leading fire ends the call.
                        if (!trailing_en)
                            burst_over = 1'b1;
                    end
                    if (!burst_over)
                    begin
                        pending = 1'b1;
                        if (max_wait_ms != 16'd0 && burst_age >= max_wait_ms)
                        begin
                            fire = 1'b1;
                            burst_age = 16'd0;
                        end
                        countdown = delay_ms;
                        counting = 1'b1;
                    end
                end
                REQ_TICK:
                begin
                    if (burst_age != 16'hFFFF)
                        burst_age = burst_age + 16'd1;
                    if (counting)
                    begin
                        if (countdown <= 16'd1)
                        begin
                            countdown = 16'd0;
                            counting = 1'b0;
                            fire = trailing_en;
                            pending = 1'b0;
                            leading_done = 1'b0;
                        end
                        else
                            countdown = countdown - 16'd1;
                    end
                end
                REQ_FLUSH:
                begin
                    if (pending)
                    begin
                        countdown = 16'd0;
                        counting = 1'b0;
                        fire = 1'b1;
                    end
                end
                default:
                begin
                    countdown = 16'd0;
                    counting = 1'b0;
                    pending = 1'b0;
                    leading_done = 1'b0;
                end
            endcase
            outcome.fire = fire;
            outcome.fire_value = fire ? last_value : 32'd0;
            outcome.pending_now = pending;
            fire_q.push_back(outcome);
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
            errors++;
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (fire_q.size() == 0)
                flag_mismatch("unexpected response", got.fire_value, 32'd0);
            else
            begin
                want = fire_q.pop_front();
                if (got.fire !== want.fire)
                    flag_mismatch("fire", 32'(got.fire), 32'(want.fire));
                if (got.fire_value !== want.fire_value)
                    flag_mismatch("fire_value", got.fire_value, want.fire_value);
                if (got.pending_now !== want.pending_now)
                    flag_mismatch("pending_now", 32'(got.pending_now), 32'(want.pending_now));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    cfg_reg_t    cfg_addr = CFG_DELAY_MS;
    logic [15:0] cfg_wdata = 16'd0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;

    debounce_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int cycles = 0;

    event_debouncer_leading_trailing_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            sb.take_request(req);
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic req_t make_req(req_type_t kind, logic [31:0] v);
        req_t r;
        r.req_type = kind;
        r.value = v;
        return r;
    endfunction

    function automatic req_t random_request();
        int pick;
        int vsel;
        req_type_t kind;
        logic [31:0] v;
        pick = $urandom_range(99);
        vsel = $urandom_range(9);
        if (pick < 35)
            kind = REQ_CALL;
        else if (pick < 80)
            kind = REQ_TICK;
        else if (pick < 90)
            kind = REQ_FLUSH;
        else
            kind = REQ_CANCEL;
        if (vsel == 0)
            v = 32'd0;
        else if (vsel == 1)
            v = 32'hFFFF_FFFF;
        else
            v = $urandom;
        return make_req(kind, v);
    endfunction

    // Holds the request payload until the transfer completes.
    task automatic send_request(req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t addr, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        sb.apply_reg(addr, data);
    endtask

    task automatic program_regs(logic [15:0] dly, logic lead, logic trail, logic [15:0] mw);
        write_reg(CFG_DELAY_MS, dly);
        write_reg(CFG_LEADING_EN, 16'($urandom_range(16'hFFFF)) & 16'hFFFE | {15'd0, lead});
        write_reg(CFG_TRAILING_EN, 16'($urandom_range(16'hFFFF)) & 16'hFFFE | {15'd0, trail});
        write_reg(CFG_MAX_WAIT_MS, mw);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int seg;
        int i;
        logic [15:0] dly;
        logic [15:0] mw;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 14;
        recv_idle = 83;

        // Zero delay expires on the first tick; flush and cancel while idle.
        program_regs(16'd0, 1'b0, 1'b1, 16'd0);
        send_request(make_req(REQ_TICK, 32'd0));
        send_request(make_req(REQ_FLUSH, 32'h1234_5678));
        send_request(make_req(REQ_CANCEL, 32'hFFFF_FFFF));
        send_request(make_req(REQ_CALL, 32'hFFFF_FFFF));
        send_request(make_req(REQ_TICK, 32'd0));
        send_request(make_req(REQ_CALL, 32'd0));
        send_request(make_req(REQ_FLUSH, 32'd0));
        send_request(make_req(REQ_TICK, 32'd0));
        send_request(make_req(REQ_CANCEL, 32'd0));
        drain_results();

        // Leading only: every call fires and nothing stays pending.
        program_regs(16'd2, 1'b1, 1'b0, 16'd0);
        send_request(make_req(REQ_CALL, 32'hA5A5_0001));
        send_request(make_req(REQ_CALL, 32'h5A5A_0002));
        send_request(make_req(REQ_TICK, 32'd0));
        send_request(make_req(REQ_FLUSH, 32'd0));
        drain_results();

        // Leading switched on mid-burst while the max wait is also due:
        // both fires land on one call.
        program_regs(16'd5, 1'b0, 1'b1, 16'd2);
        send_request(make_req(REQ_CALL, 32'h0000_00C3));
        send_request(make_req(REQ_TICK, 32'd0));
        send_request(make_req(REQ_TICK, 32'd0));
        send_request(make_req(REQ_TICK, 32'd0));
        drain_results();
        write_reg(CFG_LEADING_EN, 16'd1);
        cfg_we <= 1'b0;
        send_request(make_req(REQ_CALL, 32'h0000_00D4));
        drain_results();

        // Expiry with trailing off clears pending silently.
        program_regs(16'd1, 1'b0, 1'b0, 16'd0);
        send_request(make_req(REQ_CALL, 32'hE000_000E));
        send_request(make_req(REQ_TICK, 32'd0));
        drain_results();

        // A flushed burst stays pending while its age grows, so the next
        // call forces a max-wait fire.
        program_regs(16'hFFFF, 1'b0, 1'b1, 16'd40);
        send_request(make_req(REQ_CALL, 32'h0BAD_CAFE));
        send_request(make_req(REQ_FLUSH, 32'd0));
        for (i = 0; i < 45; i++)
            send_request(make_req(REQ_TICK, $urandom));
        send_request(make_req(REQ_CALL, 32'hC0FF_EE00));
        send_request(make_req(REQ_CANCEL, 32'd0));
        drain_results();

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 4)
            begin
                send_idle = 14;
                recv_idle = 83;
            end
            else if (seg < 8)
            begin
                send_idle = 83;
                recv_idle = 14;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            dly = 16'($urandom_range(6));
            mw = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            case (seg % 4)
                0: program_regs(16'd0, 1'($urandom_range(1)), 1'b1, 16'($urandom_range(1)));
                1: program_regs(16'hFFFF, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                16'hFFFF);
                2: program_regs(dly, 1'b1, 1'b0, mw);
                default: program_regs(dly, 1'($urandom_range(1)), 1'($urandom_range(1)), mw);
            endcase
            for (i = 0; i < SEGMENT_ITEMS; i++)
            begin
                // Now and then the sender holds off until every response is in.
                if ($urandom_range(79) == 0)
                    drain_results();
                send_request(random_request());
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.flag_mismatch("responses never received", 32'(sb.outstanding()), 32'd0);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
